FILE: sv/sha1_byte_stream_hasher_defines.svh
// Assertion macros used by the hasher's checker.
`ifndef SHA1_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHA1BSH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHA1BSH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sha1bsh_pkg.sv
// Shared types and constants of the SHA-1 byte stream hasher.
`default_nettype none

package sha1bsh_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_ABSORB  = 2'd0;
  localparam logic [1:0] FUNC_FINISH  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  // Decoded command kinds carried through the queue
  typedef enum logic [1:0] {
    OP_ABSORB,
    OP_FINISH,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // Command queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Initial hash, index 0 is H0
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants, index 0 for rounds 0..19
  localparam logic [3:0][31:0] RND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

`default_nettype wire

FILE: sv/sha1bsh_if.sv
// Valid/ready channel interfaces for the hasher's input and digest output.
`default_nettype none

interface sha1bsh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface sha1bsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  logic        failed;

  modport source (output valid, output digest_word, output word_index, output last,
                  output failed, input ready);
  modport sink   (input valid, input digest_word, input word_index, input last,
                  input failed, output ready);
endinterface

`default_nettype wire

FILE: sv/sha1_byte_stream_hasher.sv
// Top level of the streaming SHA-1 byte hasher.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    func[1:0], data_byte[7:0]
//   out_ch    out  valid/ready    digest_word[31:0], word_index[2:0], last, failed
//
// The engine takes a byte while idle; every 64th byte starts 80 rounds and one add step,
// so a long message is paced by the single round unit. Finish pads one byte per cycle,
// compresses once or twice, then sends five words; a repeated finish only sends its
// five words, a failed finish one zero word flagged failed. A four-entry command queue
// keeps accepting, until it is full, while the engine works or the output stalls.
// Reset is synchronous and active low; it loads the initial hash and clears the queue.
`default_nettype none

module sha1_byte_stream_hasher (
  input  wire logic      clk,
  input  wire logic      rst_n,
  sha1bsh_in_if.sink     in_ch,
  sha1bsh_out_if.source  out_ch
);

  sha1bsh_pkg::cmd_t push_cmd;
  sha1bsh_pkg::cmd_t pop_cmd;
  logic              push;
  logic              q_full;
  logic              pop;
  logic              q_not_empty;

  sha1bsh_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push_cmd (push_cmd),
    .push     (push)
  );

  sha1bsh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_not_empty)
  );

  sha1bsh_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .cmd_valid (q_not_empty),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: sv/sha1bsh_front.sv
// Front end: accepts input transfers, decodes the function and feeds the queue.
`default_nettype none

module sha1bsh_front (
  sha1bsh_in_if.sink          in_ch,
  input  wire logic           q_full,
  output sha1bsh_pkg::cmd_t   push_cmd,
  output logic                push
);

  logic             known;
  sha1bsh_pkg::op_t op;

  // Decode the function code; the unused code is accepted and dropped
  always_comb begin
    known = 1'b1;
    op    = sha1bsh_pkg::OP_ABSORB;
    case (in_ch.func)
      sha1bsh_pkg::FUNC_ABSORB:  op = sha1bsh_pkg::OP_ABSORB;
      sha1bsh_pkg::FUNC_FINISH:  op = sha1bsh_pkg::OP_FINISH;
      sha1bsh_pkg::FUNC_RESTART: op = sha1bsh_pkg::OP_RESTART;
      default:                   known = 1'b0;
    endcase
  end

  // Stall the source only while the queue is full
  assign in_ch.ready   = !q_full;
  assign push          = in_ch.valid && !q_full && known;
  assign push_cmd.op   = op;
  assign push_cmd.data = in_ch.data_byte;

endmodule

`default_nettype wire

FILE: sv/sha1bsh_fifo.sv
// Short command queue between the front end and the hash engine.
`default_nettype none

module sha1bsh_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sha1bsh_pkg::cmd_t  push_cmd,
  output logic                    full,
  input  wire logic               pop,
  output sha1bsh_pkg::cmd_t       pop_cmd,
  output logic                    not_empty
);

  sha1bsh_pkg::cmd_t                 q_r [sha1bsh_pkg::FIFO_DEPTH];
  logic [sha1bsh_pkg::FIFO_AW-1:0]   wr_ptr_r;
  logic [sha1bsh_pkg::FIFO_AW-1:0]   rd_ptr_r;
  logic [sha1bsh_pkg::FIFO_AW:0]     cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign full      = (cnt_r == (sha1bsh_pkg::FIFO_AW+1)'(sha1bsh_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = q_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/sha1bsh_core.sv
// Hash engine: block buffer, padding sequencer, 80-round compression, digest output.
`default_nettype none

module sha1bsh_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha1bsh_pkg::cmd_t  cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_pop,
  sha1bsh_out_if.source           out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_EMIT
  } ret_t;

  state_t           state_r;
  ret_t             ret_r;
  logic [4:0][31:0] hash_r;
  logic [511:0]     blk_r;      // sixteen-word window, oldest word on top
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [6:0]       rnd_r;
  logic [5:0]       fill_r;
  logic [63:0]      bitcnt_r;
  logic             fin_r;
  logic             err_r;
  logic             mark_r;
  logic             lenblk_r;
  logic [2:0]       idx_r;
  logic             efail_r;
  logic             ov_r;
  logic [31:0]      od_r;
  logic [2:0]       oi_r;
  logic             ol_r;
  logic             of_r;

  logic [63:0]      bitcnt_nxt;
  logic [31:0]      w_nxt;
  logic [31:0]      t_nxt;
  logic [7:0]       pad_byte;
  logic             lenblk_now;
  logic             load_ok;

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = sha1bsh_pkg::RND_K[0];
    end else if (rnd < 7'd40) begin
      k = sha1bsh_pkg::RND_K[1];
    end else if (rnd < 7'd60) begin
      k = sha1bsh_pkg::RND_K[2];
    end else begin
      k = sha1bsh_pkg::RND_K[3];
    end
    return k;
  endfunction

  // Message schedule: w[i+16] from window taps 0, 2, 8 and 13
  always_comb begin
    w_nxt = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
    w_nxt = {w_nxt[30:0], w_nxt[31]};
  end

  // One compression round
  assign t_nxt = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r
               + round_k(rnd_r) + blk_r[511:480];

  assign bitcnt_nxt = bitcnt_r + 64'd8;

  // Padding byte: mark, then zeros, then the big-endian length in the last block
  assign lenblk_now = mark_r ? lenblk_r : (fill_r < 6'd56);
  always_comb begin
    if (!mark_r) begin
      pad_byte = sha1bsh_pkg::PAD_MARK;
    end else if (lenblk_r && (fill_r[5:3] == 3'b111)) begin
      pad_byte = bitcnt_r[{~fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;
  assign load_ok = !ov_r || out_ch.ready;

  assign out_ch.valid       = ov_r;
  assign out_ch.digest_word = od_r;
  assign out_ch.word_index  = oi_r;
  assign out_ch.last        = ol_r;
  assign out_ch.failed      = of_r;

  // Sequencer, hash state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= RET_IDLE;
      hash_r   <= sha1bsh_pkg::H_INIT;
      rnd_r    <= '0;
      fill_r   <= '0;
      bitcnt_r <= '0;
      fin_r    <= 1'b0;
      err_r    <= 1'b0;
      mark_r   <= 1'b0;
      lenblk_r <= 1'b0;
      idx_r    <= '0;
      efail_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      // Load a digest word into the output; drop it once taken
      if ((state_r == ST_EMIT) && load_ok) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              sha1bsh_pkg::OP_ABSORB: begin
                if (fin_r || err_r) begin
                  err_r <= 1'b1;
                end else begin
                  blk_r    <= {blk_r[503:0], cmd.data};
                  fill_r   <= fill_r + 1'b1;
                  bitcnt_r <= bitcnt_nxt;
                  if (bitcnt_nxt == 64'd0) begin
                    err_r <= 1'b1;
                  end
                  if (fill_r == 6'd63) begin
                    a_r     <= hash_r[0];
                    b_r     <= hash_r[1];
                    c_r     <= hash_r[2];
                    d_r     <= hash_r[3];
                    e_r     <= hash_r[4];
                    rnd_r   <= '0;
                    ret_r   <= RET_IDLE;
                    state_r <= ST_ROUND;
                  end
                end
              end
              sha1bsh_pkg::OP_RESTART: begin
                hash_r   <= sha1bsh_pkg::H_INIT;
                fill_r   <= '0;
                bitcnt_r <= '0;
                fin_r    <= 1'b0;
                err_r    <= 1'b0;
              end
              sha1bsh_pkg::OP_FINISH: begin
                idx_r   <= '0;
                efail_r <= err_r;
                mark_r  <= 1'b0;
                if (err_r || fin_r) begin
                  state_r <= ST_EMIT;
                end else begin
                  state_r <= ST_PAD;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_PAD: begin
          blk_r    <= {blk_r[503:0], pad_byte};
          fill_r   <= fill_r + 1'b1;
          mark_r   <= 1'b1;
          lenblk_r <= lenblk_now;
          if (fill_r == 6'd63) begin
            a_r     <= hash_r[0];
            b_r     <= hash_r[1];
            c_r     <= hash_r[2];
            d_r     <= hash_r[3];
            e_r     <= hash_r[4];
            rnd_r   <= '0;
            ret_r   <= lenblk_now ? RET_EMIT : RET_PAD;
            state_r <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          a_r   <= t_nxt;
          b_r   <= a_r;
          c_r   <= {b_r[1:0], b_r[31:2]};
          d_r   <= c_r;
          e_r   <= d_r;
          blk_r <= {blk_r[479:0], w_nxt};
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == sha1bsh_pkg::LAST_ROUND) begin
            state_r <= ST_ADD;
          end
        end

        ST_ADD: begin
          hash_r[0] <= hash_r[0] + a_r;
          hash_r[1] <= hash_r[1] + b_r;
          hash_r[2] <= hash_r[2] + c_r;
          hash_r[3] <= hash_r[3] + d_r;
          hash_r[4] <= hash_r[4] + e_r;
          case (ret_r)
            RET_PAD: begin
              lenblk_r <= 1'b1;
              state_r  <= ST_PAD;
            end
            RET_EMIT: begin
              bitcnt_r <= '0;
              fin_r    <= 1'b1;
              state_r  <= ST_EMIT;
            end
            default: begin
              state_r <= ST_IDLE;
            end
          endcase
        end

        ST_EMIT: begin
          if (load_ok) begin
            od_r  <= efail_r ? 32'd0 : hash_r[idx_r];
            oi_r  <= idx_r;
            ol_r  <= efail_r || (idx_r == sha1bsh_pkg::LAST_WORD);
            of_r  <= efail_r;
            idx_r <= idx_r + 1'b1;
            if (efail_r || (idx_r == sha1bsh_pkg::LAST_WORD)) begin
              state_r <= ST_IDLE;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/sha1bsh_checker.sv
// Port-level checks on the digest output of the hasher, bound to the top level.
`default_nettype none

`include "sha1_byte_stream_hasher_defines.svh"

module sha1bsh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_digest_word,
  input wire logic [2:0]  out_word_index,
  input wire logic        out_last,
  input wire logic        out_failed
);

  logic [2:0] exp_idx_r;

  // Track the word position expected on the next transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_last ? 3'd0 : out_word_index + 1'b1;
    end
  end

  `SHA1BSH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digest_word) && $stable(out_word_index) && $stable(out_last) && $stable(out_failed), "stalled result changed")
  `SHA1BSH_ASSERT_IMP(a_fail_shape, out_valid && out_failed, out_digest_word == 32'd0 && out_word_index == 3'd0 && out_last, "failed result is not a lone zero word")
  `SHA1BSH_ASSERT_IMP(a_word_order, out_valid, out_word_index == exp_idx_r, "digest words out of order")
  `SHA1BSH_ASSERT_IMP(a_last_word, out_valid && !out_failed, out_last == (out_word_index == sha1bsh_pkg::LAST_WORD), "last flag not on the final digest word")

endmodule

bind sha1_byte_stream_hasher sha1bsh_checker u_sha1bsh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_last        (out_ch.last),
  .out_failed      (out_ch.failed)
);

`default_nettype wire

FILE: sim/tb_sha1_byte_stream_hasher.sv
// Self-checking testbench for the streaming SHA-1 byte hasher, with a built-in digest predictor.
module tb_sha1_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  // Func code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [31:0] K_R00 = 32'h5A827999;
  localparam logic [31:0] K_R20 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R40 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R60 = 32'hCA62C1D6;
  localparam logic [159:0] ABC_DIGEST =
    160'hA9993E36_4706816A_BA3E2571_7850C26C_9CD0D89D;

  // Grace after the last digest word: one full two-block finish and then some
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_STALL    = 400;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        failed;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha1bsh_in_if  in_ch ();
  sha1bsh_out_if out_ch ();

  sha1_byte_stream_hasher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Predicted hasher state
  logic [31:0] hash_st [5];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] bit_len;
  bit          hashed;
  bit          corrupt;

  digest_beat_t beats_due [$];

  // Run statistics
  int n_errors;
  int n_bytes;
  int n_finishes;
  int n_failed_finishes;
  int n_beats_checked;

  // Idle and stall controls
  bit src_idle_on;
  bit snk_idle_on;
  int snk_hold_req;
  int snk_hold_left;
  int snk_gap_left;

  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) hash_st[i] = SHA1_IV[i];
    fill    = 0;
    bit_len = '0;
    hashed  = 1'b0;
    corrupt = 1'b0;
  endfunction

  // Run the 80 rounds over the buffered block
  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = hash_st[0];
    b = hash_st[1];
    c = hash_st[2];
    d = hash_st[3];
    e = hash_st[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_R00;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_R20;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R40;
      end else begin
        f = b ^ c ^ d;
        k = K_R60;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_st[0] += a;
    hash_st[1] += b;
    hash_st[2] += c;
    hash_st[3] += d;
    hash_st[4] += e;
    fill = 0;
  endfunction

  // Append the marker, zeros and length; spill into a second block when needed
  function automatic void sha1_pad();
    int unsigned i;
    i = fill;
    blk[i] = sha1bsh_pkg::PAD_MARK;
    i++;
    if (i > 56) begin
      while (i < 64) begin
        blk[i] = 8'h00;
        i++;
      end
      sha1_compress();
      i = 0;
    end
    while (i < 56) begin
      blk[i] = 8'h00;
      i++;
    end
    for (int j = 0; j < 8; j++) blk[56+j] = bit_len[63-8*j -: 8];
    sha1_compress();
    for (int j = 0; j < 64; j++) blk[j] = 8'h00;
    bit_len = '0;
    hashed  = 1'b1;
  endfunction

  // Advance the predicted state by one accepted command and queue its digest words
  function automatic void sha1_apply(input logic [1:0] func, input logic [7:0] data);
    digest_beat_t beat;
    case (func)
      sha1bsh_pkg::FUNC_ABSORB: begin
        if (hashed || corrupt) begin
          corrupt = 1'b1;
        end else begin
          blk[fill] = data;
          fill++;
          bit_len += 64'd8;
          if (bit_len == '0) corrupt = 1'b1;
          if (fill == 64) sha1_compress();
          n_bytes++;
        end
      end
      sha1bsh_pkg::FUNC_RESTART: sha1_restart();
      sha1bsh_pkg::FUNC_FINISH: begin
        n_finishes++;
        if (corrupt) begin
          beat = '{word: '0, idx: '0, last: 1'b1, failed: 1'b1};
          beats_due.push_back(beat);
          n_failed_finishes++;
        end else begin
          if (!hashed) sha1_pad();
          for (int i = 0; i < 5; i++) begin
            beat = '{word: hash_st[i], idx: 3'(i), last: (i == 4), failed: 1'b0};
            beats_due.push_back(beat);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one command, optionally after a random gap, and hold it until the transfer
  task automatic send_cmd(input logic [1:0] func, input logic [7:0] data);
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.data_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sha1_apply(func, data);
  endtask

  // Drop valid and hold off until every predicted digest word has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  // Send len random bytes, with an occasional ignored code mixed in when noisy is set
  task automatic send_bytes(input int len, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 23) == 0) send_cmd(FUNC_UNUSED, 8'($urandom));
      send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'($urandom));
    end
  endtask

  task automatic test_directed();
    // Empty message, then a repeat of its digest
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'hFF);
    // Byte after finish poisons the stream; finish reports failure, twice
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'hFF);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    // Ignored code must not disturb anything
    send_cmd(FUNC_UNUSED, 8'hA5);
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h5A);
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'h61);
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'h62);
    send_cmd(FUNC_UNUSED, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'h63);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    if ({hash_st[0], hash_st[1], hash_st[2], hash_st[3], hash_st[4]} !== ABC_DIGEST)
      $error("predictor: abc digest expected %h, got %h", ABC_DIGEST,
             {hash_st[0], hash_st[1], hash_st[2], hash_st[3], hash_st[4]});
    // Extreme byte values
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'hFF);
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'h80);
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'h7F);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    // Restart clears the error
    send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'h01);
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
  endtask

  task automatic test_random_messages();
    int pad_lens [9];
    int start_bytes;
    int len;
    int kind;
    pad_lens    = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    start_bytes = n_bytes;
    while (n_bytes - start_bytes < 120) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 11);
      // Mostly short messages; the rest sit around the padding boundaries
      if ($urandom_range(0, 4) < 3) len = $urandom_range(0, 12);
      else len = pad_lens[$urandom_range(0, 8)];
      // kind 0 skips the restart, so bytes after a finished message corrupt it
      if (kind != 0) send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'($urandom));
      send_bytes(len, 1'b1);
      // kind 1 drops the message unfinished
      if (kind == 1) continue;
      send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'($urandom));
      // kind 2 pokes a byte in after the finish
      if (kind == 2) begin
        send_cmd(sha1bsh_pkg::FUNC_ABSORB, 8'($urandom));
        send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'($urandom));
    end
  endtask

  task automatic test_sink_stall();
    src_idle_on  = 1'b0;
    snk_idle_on  = 1'b1;
    snk_hold_req = LONG_STALL;
    // Repeated finishes pile up digest words behind the stalled output
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h00);
    send_bytes(5, 1'b0);
    repeat (6) send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h00);
    send_bytes(3, 1'b0);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
  endtask

  task automatic test_back_to_back();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h00);
    send_bytes(64, 1'b0);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h00);
    send_bytes(3, 1'b0);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
    send_cmd(sha1bsh_pkg::FUNC_RESTART, 8'h00);
    send_bytes(56, 1'b0);
    send_cmd(sha1bsh_pkg::FUNC_FINISH, 8'h00);
  endtask

  // Drive ready: long holds first, then random stall bursts
  always @(posedge clk) begin
    if (snk_hold_req > 0) begin
      snk_hold_left = snk_hold_req;
      snk_hold_req  = 0;
    end
    if (snk_hold_left > 0) begin
      snk_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (snk_gap_left > 0) begin
      snk_gap_left--;
      out_ch.ready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
      snk_gap_left = $urandom_range(1, 7) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each digest transfer against the oldest predicted word
  always @(posedge clk) begin : check_digest
    digest_beat_t exp_beat;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (beats_due.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", out_ch.digest_word, out_ch.word_index);
        n_errors++;
      end else begin
        exp_beat = beats_due.pop_front();
        n_beats_checked++;
        if (out_ch.digest_word !== exp_beat.word) begin
          $error("digest_word: expected %h, got %h", exp_beat.word, out_ch.digest_word);
          n_errors++;
        end
        if (out_ch.word_index !== exp_beat.idx) begin
          $error("word_index: expected %0d, got %0d", exp_beat.idx, out_ch.word_index);
          n_errors++;
        end
        if (out_ch.last !== exp_beat.last) begin
          $error("last: expected %b, got %b", exp_beat.last, out_ch.last);
          n_errors++;
        end
        if (out_ch.failed !== exp_beat.failed) begin
          $error("failed: expected %b, got %b", exp_beat.failed, out_ch.failed);
          n_errors++;
        end
      end
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.func      = sha1bsh_pkg::FUNC_ABSORB;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    sha1_restart();
    for (int j = 0; j < 64; j++) blk[j] = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_drained();
    test_random_messages();
    test_sink_stall();
    wait_drained();
    test_back_to_back();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (beats_due.size() != 0) begin
      $error("%0d digest words never arrived", beats_due.size());
      n_errors++;
    end
    $display("Run covered %0d message bytes and %0d finishes (%0d reporting corruption),",
             n_bytes, n_finishes, n_failed_finishes);
    $display("with %0d digest words compared against the predicted hash.", n_beats_checked);
    if (n_errors == 0) begin
      $display("tb_sha1_byte_stream_hasher: clean");
    end else begin
      $display("tb_sha1_byte_stream_hasher: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8ms;
    $display("tb_sha1_byte_stream_hasher: errors");
    $finish;
  end

endmodule
